/* hdl/magpoll_pkg.sv */
package magpoll_pkg;

  // Event codes carried by one input beat
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STEP  = 2'd1,
    OP_TICK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // Sequencer phases, one-hot in the state register
  typedef enum logic [4:0] {
    PH_INIT  = 5'b00001,
    PH_REV   = 5'b00010,
    PH_READ  = 5'b00100,
    PH_ERROR = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_e;

  // Phase codes as shown on the result port
  localparam logic [2:0] PHASE_CODE_INIT  = 3'd0;
  localparam logic [2:0] PHASE_CODE_REV   = 3'd1;
  localparam logic [2:0] PHASE_CODE_READ  = 3'd2;
  localparam logic [2:0] PHASE_CODE_ERROR = 3'd3;
  localparam logic [2:0] PHASE_CODE_DONE  = 3'd4;

  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_INIT = 2'd1,
    ACC_REV  = 2'd2,
    ACC_DATA = 2'd3
  } access_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_BUS  = 2'd1,
    ERR_CHIP = 2'd2
  } err_e;

  // Configuration register indexes
  localparam logic [1:0] REG_UNIT_GAUSS = 2'd0;
  localparam logic [1:0] REG_PERMIT     = 2'd1;
  localparam logic [1:0] REG_SETTLE     = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PERMIT_W   = 16;
  localparam int unsigned SETTLE_W   = 8;
  localparam int unsigned REV_W      = 8;

  localparam logic                RESET_UNIT_GAUSS = 1'b1;
  localparam logic [PERMIT_W-1:0] RESET_PERMIT     = 16'd500;
  localparam logic [SETTLE_W-1:0] RESET_SETTLE     = 8'd10;

  localparam logic [REV_W-1:0] REV_BLANK   = 8'h00;
  localparam logic [REV_W-1:0] REV_INVALID = 8'hFF;

  // Datapath widths of the field conversion
  localparam int unsigned RAW_W      = 24;
  localparam int unsigned FIELD_W    = 40;
  localparam int unsigned CHUNK_W    = 22;
  localparam int unsigned MULT_W     = 3 * CHUNK_W;
  localparam int unsigned PROD_W     = RAW_W + CHUNK_W;
  localparam int unsigned LO_W       = PROD_W + CHUNK_W + 1;
  localparam int unsigned SUM_W      = RAW_W + MULT_W;
  localparam int unsigned FRAC_SHIFT = 52;
  localparam int unsigned Q_W        = SUM_W - FRAC_SHIFT;

  // Sensor scaling: 75 LSB per microtesla, 10000 gauss per tesla, Z by 0.667
  localparam int unsigned SENSOR_GAIN     = 75;
  localparam int unsigned LSB_PER_TESLA   = 1000000;
  localparam int unsigned GAUSS_PER_TESLA = 10000;
  localparam int unsigned Z_NUM           = 667;
  localparam int unsigned Z_DEN           = 1000;
  localparam int unsigned FRAC_GAUSS      = 24;
  localparam int unsigned FRAC_TESLA      = 40;

  localparam logic [127:0] DEN_TESLA = 128'(SENSOR_GAIN) * 128'(LSB_PER_TESLA);
  localparam logic [127:0] DEN_GAUSS = DEN_TESLA / 128'(GAUSS_PER_TESLA);

  // Reciprocals scaled by 2^(FRAC_SHIFT + output fraction bits), truncated; the error stays below
  // the smallest distance of a true result from a rounding boundary
  localparam logic [127:0] RECIP_GAUSS_W =
    (128'd1 << (FRAC_GAUSS + FRAC_SHIFT)) / DEN_GAUSS;
  localparam logic [127:0] RECIP_TESLA_W =
    (128'd1 << (FRAC_TESLA + FRAC_SHIFT)) / DEN_TESLA;
  localparam logic [127:0] RECIP_GAUSS_Z_W =
    ((128'd1 << (FRAC_GAUSS + FRAC_SHIFT)) * 128'(Z_NUM)) / (DEN_GAUSS * 128'(Z_DEN));
  localparam logic [127:0] RECIP_TESLA_Z_W =
    ((128'd1 << (FRAC_TESLA + FRAC_SHIFT)) * 128'(Z_NUM)) / (DEN_TESLA * 128'(Z_DEN));

  localparam logic [MULT_W-1:0] RECIP_GAUSS   = RECIP_GAUSS_W[MULT_W-1:0];
  localparam logic [MULT_W-1:0] RECIP_TESLA   = RECIP_TESLA_W[MULT_W-1:0];
  localparam logic [MULT_W-1:0] RECIP_GAUSS_Z = RECIP_GAUSS_Z_W[MULT_W-1:0];
  localparam logic [MULT_W-1:0] RECIP_TESLA_Z = RECIP_TESLA_Z_W[MULT_W-1:0];

  typedef struct packed {
    logic                unit_gauss;
    logic [PERMIT_W-1:0] permit_amount;
    logic [SETTLE_W-1:0] settle_ticks;
  } cfg_t;

  // Outcome of one event, carried down the pipeline with the fields
  typedef struct packed {
    logic [2:0] phase;
    access_e    access;
    err_e       err;
    logic       done;
    logic       fresh;
    logic       load;
  } step_t;

  // Stage load enables of the conversion pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

  function automatic logic [MULT_W-1:0] pick_recip(input logic gauss, input logic zaxis);
    logic [MULT_W-1:0] r;
    if (gauss) begin
      r = zaxis ? RECIP_GAUSS_Z : RECIP_GAUSS;
    end else begin
      r = zaxis ? RECIP_TESLA_Z : RECIP_TESLA;
    end
    return r;
  endfunction

  function automatic logic [2:0] phase_code(input phase_e ph);
    logic [2:0] c;
    unique case (ph)
      PH_INIT:  c = PHASE_CODE_INIT;
      PH_REV:   c = PHASE_CODE_REV;
      PH_READ:  c = PHASE_CODE_READ;
      PH_ERROR: c = PHASE_CODE_ERROR;
      PH_DONE:  c = PHASE_CODE_DONE;
      default:  c = PHASE_CODE_INIT;
    endcase
    return c;
  endfunction

endpackage

/* hdl/magnetometer_poll_sequencer_unit.sv */
// An accepted input beat passes through pipeline stages 1 to 4 and the result register before it is presented.
// Throughput: one input beat per cycle while the result channel is not stalled; the phase decision is
// combinational and the field conversion runs in a four-stage split-multiplier pipeline.
// Reset (rst_ni low, asynchronous): phase init, counters and flags clear, held fields zero,
// configuration back to its defaults, pipeline empty. No clearing pass follows reset.
module magnetometer_poll_sequencer_unit
  import magpoll_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                operation_i,
  input  logic                      soft_reset_i,
  input  logic                      bus_ok_i,
  input  logic [REV_W-1:0]          revision_i,
  input  logic [RAW_W-1:0]          raw_x_i,
  input  logic [RAW_W-1:0]          raw_y_i,
  input  logic [RAW_W-1:0]          raw_z_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                phase_now_o,
  output logic [1:0]                access_done_o,
  output logic [1:0]                error_code_o,
  output logic                      done_flag_o,
  output logic                      fresh_data_o,
  output logic signed [FIELD_W-1:0] field_x_o,
  output logic signed [FIELD_W-1:0] field_y_o,
  output logic signed [FIELD_W-1:0] field_z_o,
  // configuration write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i
);

  cfg_t     cfg;
  step_t    step;
  step_t    st1_q, st2_q, st3_q, st4_q;
  logic     v1_q, v2_q, v3_q, v4_q;
  logic     out_valid_q;
  logic     out_free;
  logic     accept;
  pipe_en_t en;
  logic [MULT_W-1:0] recip_xy, recip_z;
  logic signed [FIELD_W-1:0] conv_x, conv_y, conv_z;
  logic signed [FIELD_W-1:0] held_x_q, held_y_q, held_z_q;
  step_t    res_q;
  logic signed [FIELD_W-1:0] res_x_q, res_y_q, res_z_q;

  magpoll_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Stage enables: a stage loads when empty or when its content moves on
  assign out_free   = !out_valid_q || !out_stall_i;
  assign en.s4      = !v4_q || out_free;
  assign en.s3      = !v3_q || en.s4;
  assign en.s2      = !v2_q || en.s3;
  assign en.s1      = !v1_q || en.s2;
  assign in_stall_o = !en.s1;
  assign accept     = in_valid_i && en.s1;

  magpoll_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .operation_i  (operation_i),
    .soft_reset_i (soft_reset_i),
    .bus_ok_i     (bus_ok_i),
    .revision_i   (revision_i),
    .cfg_i        (cfg),
    .step_o       (step)
  );

  assign recip_xy = pick_recip(cfg.unit_gauss, 1'b0);
  assign recip_z  = pick_recip(cfg.unit_gauss, 1'b1);

  // X and Y swap places here
  magpoll_conv u_conv_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .raw_i   (raw_y_i),
    .recip_i (recip_xy),
    .field_o (conv_x)
  );

  magpoll_conv u_conv_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .raw_i   (raw_x_i),
    .recip_i (recip_xy),
    .field_o (conv_y)
  );

  magpoll_conv u_conv_z (
    .clk_i   (clk_i),
    .en_i    (en),
    .raw_i   (raw_z_i),
    .recip_i (recip_z),
    .field_o (conv_z)
  );

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= accept;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en.s4) v4_q <= v3_q;
      if (out_free) out_valid_q <= v4_q;
    end
  end

  // Carry the step outcome alongside the conversion
  always_ff @(posedge clk_i) begin
    if (en.s1) st1_q <= step;
    if (en.s2) st2_q <= st1_q;
    if (en.s3) st3_q <= st2_q;
    if (en.s4) st4_q <= st3_q;
  end

  // Held fields: take the new conversion when a successful read leaves stage 4
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_x_q <= '0;
      held_y_q <= '0;
      held_z_q <= '0;
    end else if (v4_q && out_free && st4_q.load) begin
      held_x_q <= conv_x;
      held_y_q <= conv_y;
      held_z_q <= conv_z;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk_i) begin
    if (v4_q && out_free) begin
      res_q   <= st4_q;
      res_x_q <= st4_q.load ? conv_x : held_x_q;
      res_y_q <= st4_q.load ? conv_y : held_y_q;
      res_z_q <= st4_q.load ? conv_z : held_z_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign phase_now_o   = res_q.phase;
  assign access_done_o = res_q.access;
  assign error_code_o  = res_q.err;
  assign done_flag_o   = res_q.done;
  assign fresh_data_o  = res_q.fresh;
  assign field_x_o     = res_x_q;
  assign field_y_o     = res_y_q;
  assign field_z_o     = res_z_q;

endmodule

/* hdl/magpoll_cfg.sv */
module magpoll_cfg
  import magpoll_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic                unit_gauss_q;
  logic [PERMIT_W-1:0] permit_amount_q;
  logic [SETTLE_W-1:0] settle_ticks_q;

  // Always ready: every write beat is taken and registered
  assign cfg_ready_o = 1'b1;

  // Decode the index and take the write beat; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_gauss_q    <= RESET_UNIT_GAUSS;
      permit_amount_q <= RESET_PERMIT;
      settle_ticks_q  <= RESET_SETTLE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_UNIT_GAUSS: unit_gauss_q    <= cfg_data_i[0];
        REG_PERMIT:     permit_amount_q <= cfg_data_i[PERMIT_W-1:0];
        REG_SETTLE:     settle_ticks_q  <= cfg_data_i[SETTLE_W-1:0];
        default:        ;
      endcase
    end
  end

  assign cfg_o = '{unit_gauss:    unit_gauss_q,
                   permit_amount: permit_amount_q,
                   settle_ticks:  settle_ticks_q};

endmodule

/* hdl/magpoll_ctrl.sv */
module magpoll_ctrl
  import magpoll_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [1:0]       operation_i,
  input  logic             soft_reset_i,
  input  logic             bus_ok_i,
  input  logic [REV_W-1:0] revision_i,
  input  cfg_t             cfg_i,
  output step_t            step_o
);

  phase_e              phase_q, phase_d;
  logic [PERMIT_W-1:0] permit_q, permit_d;
  logic [SETTLE_W-1:0] wait_q, wait_d;
  logic                complete_q, complete_d;
  logic                new_data_q, new_data_d;
  access_e             access;
  err_e                err;
  logic                load;

  // Decide the next phase for this event
  always_comb begin
    phase_d    = phase_q;
    permit_d   = permit_q;
    wait_d     = wait_q;
    complete_d = complete_q;
    new_data_d = new_data_q;
    access     = ACC_NONE;
    err        = ERR_NONE;
    load       = 1'b0;
    if (accept_i) begin
      unique case (op_e'(operation_i))
        OP_START: begin
          phase_d    = (soft_reset_i || (permit_q == '0)) ? PH_INIT : PH_READ;
          complete_d = 1'b0;
        end
        OP_STEP: begin
          // hold everything while the settle wait runs
          if (wait_q == '0) begin
            unique case (phase_q)
              PH_INIT: begin
                access = ACC_INIT;
                if (!bus_ok_i) begin
                  phase_d = PH_ERROR;
                  err     = ERR_BUS;
                end else begin
                  wait_d   = cfg_i.settle_ticks;
                  permit_d = cfg_i.permit_amount;
                  phase_d  = PH_REV;
                end
              end
              PH_REV: begin
                access = ACC_REV;
                if (!bus_ok_i) begin
                  phase_d = PH_ERROR;
                  err     = ERR_BUS;
                end else if ((revision_i == REV_BLANK) || (revision_i == REV_INVALID)) begin
                  phase_d = PH_ERROR;
                  err     = ERR_CHIP;
                end else begin
                  phase_d = PH_READ;
                end
              end
              PH_READ: begin
                access = ACC_DATA;
                if (!bus_ok_i) begin
                  phase_d = PH_ERROR;
                  err     = ERR_BUS;
                end else begin
                  load       = 1'b1;
                  new_data_d = 1'b1;
                  if (permit_q != '0) begin
                    permit_d = permit_q - 1'b1;
                  end
                  phase_d = PH_DONE;
                end
              end
              PH_ERROR: begin
                phase_d    = PH_DONE;
                complete_d = 1'b1;
              end
              PH_DONE: begin
                complete_d = 1'b1;
              end
              default: begin
                phase_d = PH_INIT;
              end
            endcase
          end
        end
        OP_TICK: begin
          if (wait_q != '0) begin
            wait_d = wait_q - 1'b1;
          end
        end
        OP_CLEAR: begin
          new_data_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Advance the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_INIT;
      permit_q   <= '0;
      wait_q     <= '0;
      complete_q <= 1'b0;
      new_data_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      permit_q   <= permit_d;
      wait_q     <= wait_d;
      complete_q <= complete_d;
      new_data_q <= new_data_d;
    end
  end

  assign step_o = '{phase:  phase_code(phase_d),
                    access: access,
                    err:    err,
                    done:   complete_d,
                    fresh:  new_data_d,
                    load:   load};

endmodule

/* hdl/magpoll_conv.sv */
module magpoll_conv
  import magpoll_pkg::*;
(
  input  logic                      clk_i,
  input  pipe_en_t                  en_i,
  input  logic [RAW_W-1:0]          raw_i,
  input  logic [MULT_W-1:0]         recip_i,
  output logic signed [FIELD_W-1:0] field_o
);

  logic [RAW_W-1:0]  mag_q;
  logic              neg1_q, neg2_q, neg3_q, neg4_q;
  logic [PROD_W-1:0] p0_q, p1_q, p2_q, p2b_q;
  logic [LO_W-1:0]   lo_q;
  logic [Q_W-1:0]    q_q;
  logic [SUM_W-1:0]  sum;
  logic [FIELD_W-1:0] q_ext;

  // Stage 1: sign and magnitude of the raw reading
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      neg1_q <= raw_i[RAW_W-1];
      mag_q  <= raw_i[RAW_W-1] ? (~raw_i + 1'b1) : raw_i;
    end
  end

  // Stage 2: three partial products against the reciprocal
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      neg2_q <= neg1_q;
      p0_q   <= PROD_W'(mag_q) * PROD_W'(recip_i[CHUNK_W-1:0]);
      p1_q   <= PROD_W'(mag_q) * PROD_W'(recip_i[2*CHUNK_W-1:CHUNK_W]);
      p2_q   <= PROD_W'(mag_q) * PROD_W'(recip_i[3*CHUNK_W-1:2*CHUNK_W]);
    end
  end

  // Stage 3: fold the low products with the rounding half
  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      neg3_q <= neg2_q;
      p2b_q  <= p2_q;
      lo_q   <= LO_W'(p0_q) + (LO_W'(p1_q) << CHUNK_W) + (LO_W'(1) << (FRAC_SHIFT - 1));
    end
  end

  // Stage 4: add the top product and drop the fraction
  assign sum = SUM_W'(lo_q) + (SUM_W'(p2b_q) << (2 * CHUNK_W));

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      neg4_q <= neg3_q;
      q_q    <= sum[SUM_W-1:FRAC_SHIFT];
    end
  end

  // Restore the sign
  assign q_ext   = FIELD_W'(q_q);
  assign field_o = neg4_q ? $signed(~q_ext + 1'b1) : $signed(q_ext);

endmodule

/* hdl/magpoll_chk.sv */
module magpoll_chk
  import magpoll_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [2:0]                phase_now_o,
  input logic [1:0]                access_done_o,
  input logic [1:0]                error_code_o,
  input logic                      done_flag_o,
  input logic                      fresh_data_o,
  input logic signed [FIELD_W-1:0] field_x_o,
  input logic signed [FIELD_W-1:0] field_y_o,
  input logic signed [FIELD_W-1:0] field_z_o
);

  // A stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(phase_now_o)
      && $stable(field_x_o) && $stable(field_y_o) && $stable(field_z_o))
    else $error("result beat changed while stalled");

  // An error is raised only by a bus access and lands in the error phase
  a_err_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != ERR_NONE)
      |-> (phase_now_o == PHASE_CODE_ERROR) && (access_done_o != ACC_NONE))
    else $error("error reported outside the error phase");

  // A good data read completes with fresh data
  a_read_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (access_done_o == ACC_DATA) && (error_code_o == ERR_NONE)
      |-> fresh_data_o && (phase_now_o == PHASE_CODE_DONE))
    else $error("good read without fresh data");

  // The complete flag is only ever seen in the complete phase
  a_done_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_flag_o |-> (phase_now_o == PHASE_CODE_DONE))
    else $error("complete flag outside the complete phase");

endmodule

bind magnetometer_poll_sequencer_unit magpoll_chk u_magpoll_chk (.*);
